>>> design/xtl_pkg.sv
package xtl_pkg;

	typedef enum logic [3:0] {
		K_TEXT    = 4'd0,
		K_CMT     = 4'd1,
		K_CD      = 4'd2,
		K_PI      = 4'd3,
		K_DIR     = 4'd4,
		K_ETAG    = 4'd5,
		K_STAG    = 4'd6,
		K_TAGEND  = 4'd7,
		K_ANAME   = 4'd8,
		K_AVAL    = 4'd9,
		K_ERR     = 4'd10,
		K_EOF     = 4'd11
	} kind_t;

	// most results one item can cause (end of stream inside a value entity)
	localparam int unsigned BUNDLE_MAX = 4;
	localparam int unsigned QDEPTH     = 4;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic        valid;
		logic        last;
	} res_t;

	typedef struct packed {
		res_t [BUNDLE_MAX-1:0] res;
		logic [2:0]            cnt;
	} bundle_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QM    = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
	endfunction

	function automatic logic is_name(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c == 8'h5F) || (c == 8'h3A) || (c == 8'h2D) || (c == 8'h2E) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

	// letters of the CDATA keyword
	function automatic logic [7:0] cdata_char(logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0:    r = 8'h43;
			3'd1:    r = 8'h44;
			3'd2:    r = 8'h41;
			3'd3:    r = 8'h54;
			default: r = 8'h41;
		endcase
		return r;
	endfunction

	function automatic res_t mk(kind_t k, logic [7:0] ch, logic v, logic l);
		res_t r;
		r.kind  = k;
		r.ch    = ch;
		r.valid = v;
		r.last  = l;
		return r;
	endfunction

endpackage

>>> design/xtl_in_if.sv
interface xtl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;

	modport source (output valid, in_byte, end_of_stream, input ready);
	modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

>>> design/xtl_out_if.sv
interface xtl_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_kind;
	logic [7:0] out_char;
	logic       char_valid;
	logic       token_last;
	logic       result_last;

	modport source (output valid, token_kind, out_char, char_valid, token_last, result_last,
		input ready);
	modport sink   (input valid, token_kind, out_char, char_valid, token_last, result_last,
		output ready);
endinterface

>>> design/xtl_front.sv
module xtl_front #(
	parameter int unsigned ENTITY_NAME_MAX = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	xtl_in_if.sink            items,
	input  logic              full,
	output logic              push,
	output xtl_pkg::bundle_t  push_data
);

	localparam int unsigned LW = $clog2(ENTITY_NAME_MAX + 2);
	localparam int unsigned IW = $clog2(ENTITY_NAME_MAX);
	localparam logic [LW-1:0] LEN_MAX  = LW'(ENTITY_NAME_MAX);
	localparam logic [LW-1:0] LEN_LONG = LW'(ENTITY_NAME_MAX + 1);

	typedef enum logic [4:0] {
		ST_OUT, ST_TEXT_ENT, ST_LT, ST_BANG, ST_CMT_DASH, ST_CMT, ST_CD_KEY, ST_CD,
		ST_PI, ST_DIR, ST_ETAG, ST_STAG, ST_TAG, ST_TAG_SLASH, ST_TAG_QM, ST_EQ,
		ST_VAL, ST_VAL_ENT, ST_ANAME
	} state_t;

	localparam logic [2:0] KW_MISMATCH = 3'd7;
	localparam logic [2:0] KW_DONE     = 3'd5;

	state_t        state_q, ns;
	logic [1:0]    held_q, nheld;
	logic [LW-1:0] len_q, nlen;
	logic [2:0]    kw_q, nkw;
	logic          quote_q, nquote;
	logic          open_q, nopen;
	logic [7:0]    ent_q [ENTITY_NAME_MAX];
	logic          ent_we;

	xtl_pkg::res_t [xtl_pkg::BUNDLE_MAX-1:0] res;
	logic [2:0]    n;
	logic          ent_hit;
	logic [7:0]    ent_code;
	logic          acc;
	logic [7:0]    c;

	assign c     = items.in_byte;
	assign acc   = items.valid && items.ready;
	assign items.ready = !full;

	// exact match against the five predefined entities
	always_comb begin
		ent_hit  = 1'b1;
		ent_code = xtl_pkg::CH_AMP;
		if (len_q == LW'(3) && ent_q[0] == 8'h61 && ent_q[1] == 8'h6D && ent_q[2] == 8'h70)
			ent_code = xtl_pkg::CH_AMP;
		else if (len_q == LW'(2) && ent_q[0] == 8'h6C && ent_q[1] == 8'h74)
			ent_code = xtl_pkg::CH_LT;
		else if (len_q == LW'(2) && ent_q[0] == 8'h67 && ent_q[1] == 8'h74)
			ent_code = xtl_pkg::CH_GT;
		else if (len_q == LW'(4) && ent_q[0] == 8'h61 && ent_q[1] == 8'h70 &&
				ent_q[2] == 8'h6F && ent_q[3] == 8'h73)
			ent_code = xtl_pkg::CH_SQ;
		else if (len_q == LW'(4) && ent_q[0] == 8'h71 && ent_q[1] == 8'h75 &&
				ent_q[2] == 8'h6F && ent_q[3] == 8'h74)
			ent_code = xtl_pkg::CH_DQ;
		else
			ent_hit = 1'b0;
	end

	always_comb begin
		logic          do_tag;
		xtl_pkg::kind_t nk;
		logic [7:0]    mark;
		do_tag = 1'b0;
		nk     = xtl_pkg::K_ANAME;
		mark   = xtl_pkg::CH_DASH;
		n      = 3'd0;
		res    = '0;
		ns     = state_q;
		nheld  = held_q;
		nlen   = len_q;
		nkw    = kw_q;
		nquote = quote_q;
		nopen  = open_q;
		ent_we = 1'b0;
		if (items.end_of_stream) begin
			unique case (state_q)
				ST_TEXT_ENT: begin
					if (ent_hit) begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_TEXT, ent_code, 1'b1, 1'b0); n++;
					end
					res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_TEXT, 8'd0, 1'b0, 1'b1); n++;
				end
				ST_LT, ST_BANG, ST_CMT_DASH, ST_CD_KEY, ST_TAG, ST_TAG_SLASH, ST_TAG_QM,
				ST_EQ: begin
					res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_ERR, 8'd0, 1'b0, 1'b1); n++;
				end
				ST_CMT, ST_CD: begin
					nk   = (state_q == ST_CMT) ? xtl_pkg::K_CMT : xtl_pkg::K_CD;
					mark = (state_q == ST_CMT) ? xtl_pkg::CH_DASH : xtl_pkg::CH_RBRK;
					if (held_q >= 2'd1) begin
						res[n[1:0]] = xtl_pkg::mk(nk, mark, 1'b1, 1'b0); n++;
					end
					if (held_q >= 2'd2) begin
						res[n[1:0]] = xtl_pkg::mk(nk, mark, 1'b1, 1'b0); n++;
					end
					res[n[1:0]] = xtl_pkg::mk(nk, 8'd0, 1'b0, 1'b1); n++;
				end
				ST_PI, ST_DIR, ST_ETAG, ST_STAG, ST_ANAME: begin
					case (state_q)
						ST_PI:   nk = xtl_pkg::K_PI;
						ST_DIR:  nk = xtl_pkg::K_DIR;
						ST_ETAG: nk = xtl_pkg::K_ETAG;
						ST_STAG: nk = xtl_pkg::K_STAG;
						default: nk = xtl_pkg::K_ANAME;
					endcase
					res[n[1:0]] = xtl_pkg::mk(nk, 8'd0, 1'b0, 1'b1); n++;
					res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_ERR, 8'd0, 1'b0, 1'b1); n++;
				end
				ST_VAL, ST_VAL_ENT: begin
					if (state_q == ST_VAL_ENT && ent_hit) begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_AVAL, ent_code, 1'b1, 1'b0); n++;
					end
					res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_AVAL, 8'd0, 1'b0, 1'b1); n++;
					res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_ERR, 8'd0, 1'b0, 1'b1); n++;
				end
				default: begin
					if (open_q) begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_TEXT, 8'd0, 1'b0, 1'b1); n++;
					end
				end
			endcase
			res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_EOF, 8'd0, 1'b0, 1'b1); n++;
			ns     = ST_OUT;
			nheld  = 2'd0;
			nlen   = '0;
			nkw    = 3'd0;
			nquote = 1'b0;
			nopen  = 1'b0;
		end else begin
			unique case (state_q)
				ST_TEXT_ENT, ST_VAL_ENT: begin
					if (c != xtl_pkg::CH_SEMI) begin
						if (len_q < LEN_MAX) begin
							ent_we = 1'b1;
							nlen   = len_q + LW'(1);
						end else begin
							nlen = LEN_LONG;
						end
					end else if (state_q == ST_TEXT_ENT) begin
						if (ent_hit) begin
							res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_TEXT, ent_code, 1'b1, 1'b0); n++;
						end else begin
							res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_TEXT, 8'd0, 1'b0, 1'b1); n++;
							nopen = 1'b0;
						end
						ns = ST_OUT;
					end else if (ent_hit) begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_AVAL, ent_code, 1'b1, 1'b0); n++;
						ns = ST_VAL;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_AVAL, 8'd0, 1'b0, 1'b1); n++;
						ns = ST_TAG;
					end
				end
				ST_LT: begin
					if (c == xtl_pkg::CH_QM) ns = ST_PI;
					else if (c == xtl_pkg::CH_BANG) ns = ST_BANG;
					else if (c == xtl_pkg::CH_SLASH) ns = ST_ETAG;
					else if (xtl_pkg::is_name(c)) begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_STAG, c, 1'b1, 1'b0); n++;
						ns = ST_STAG;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_STAG, 8'd0, 1'b0, 1'b1); n++;
						do_tag = 1'b1;
					end
				end
				ST_BANG: begin
					if (c == xtl_pkg::CH_DASH) ns = ST_CMT_DASH;
					else if (c == xtl_pkg::CH_LBRK) begin
						nkw = 3'd0;
						ns  = ST_CD_KEY;
					end else if (xtl_pkg::is_name(c)) begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_DIR, c, 1'b1, 1'b0); n++;
						ns = ST_DIR;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_DIR, 8'd0, 1'b0, 1'b1); n++;
						do_tag = 1'b1;
					end
				end
				ST_CMT_DASH: begin
					if (c == xtl_pkg::CH_DASH) begin
						nheld = 2'd0;
						ns    = ST_CMT;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_ERR, 8'd0, 1'b0, 1'b1); n++;
						ns = ST_OUT;
					end
				end
				ST_CMT, ST_CD: begin
					nk   = (state_q == ST_CMT) ? xtl_pkg::K_CMT : xtl_pkg::K_CD;
					mark = (state_q == ST_CMT) ? xtl_pkg::CH_DASH : xtl_pkg::CH_RBRK;
					if (c == mark) begin
						if (held_q < 2'd2) nheld = held_q + 2'd1;
						else begin
							res[n[1:0]] = xtl_pkg::mk(nk, mark, 1'b1, 1'b0); n++;
						end
					end else if (c == xtl_pkg::CH_GT && held_q == 2'd2) begin
						nheld  = 2'd0;
						res[n[1:0]] = xtl_pkg::mk(nk, 8'd0, 1'b0, 1'b1); n++;
						ns     = ST_OUT;
					end else begin
						if (held_q >= 2'd1) begin
							res[n[1:0]] = xtl_pkg::mk(nk, mark, 1'b1, 1'b0); n++;
						end
						if (held_q >= 2'd2) begin
							res[n[1:0]] = xtl_pkg::mk(nk, mark, 1'b1, 1'b0); n++;
						end
						nheld  = 2'd0;
						res[n[1:0]] = xtl_pkg::mk(nk, c, 1'b1, 1'b0); n++;
					end
				end
				ST_CD_KEY: begin
					if (xtl_pkg::is_name(c)) begin
						if (kw_q < KW_DONE && c == xtl_pkg::cdata_char(kw_q))
							nkw = kw_q + 3'd1;
						else
							nkw = KW_MISMATCH;
					end else if (kw_q == KW_DONE && c == xtl_pkg::CH_LBRK) begin
						nheld = 2'd0;
						ns    = ST_CD;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_ERR, 8'd0, 1'b0, 1'b1); n++;
						ns = ST_OUT;
					end
				end
				ST_PI, ST_DIR, ST_ETAG, ST_STAG, ST_ANAME: begin
					case (state_q)
						ST_PI:   nk = xtl_pkg::K_PI;
						ST_DIR:  nk = xtl_pkg::K_DIR;
						ST_ETAG: nk = xtl_pkg::K_ETAG;
						ST_STAG: nk = xtl_pkg::K_STAG;
						default: nk = xtl_pkg::K_ANAME;
					endcase
					if (xtl_pkg::is_name(c)) begin
						res[n[1:0]] = xtl_pkg::mk(nk, c, 1'b1, 1'b0); n++;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(nk, 8'd0, 1'b0, 1'b1); n++;
						do_tag = 1'b1;
					end
				end
				ST_TAG: do_tag = 1'b1;
				ST_TAG_SLASH, ST_TAG_QM: begin
					if (c == xtl_pkg::CH_GT) begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_TAGEND,
							(state_q == ST_TAG_SLASH) ? xtl_pkg::CH_SLASH : xtl_pkg::CH_QM,
							1'b1, 1'b1);
						n++;
						ns = ST_OUT;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_ERR, 8'd0, 1'b0, 1'b1); n++;
						ns = ST_TAG;
					end
				end
				ST_EQ: begin
					if (xtl_pkg::is_space(c)) ns = ST_EQ;
					else if (c == xtl_pkg::CH_DQ) begin
						nquote = 1'b0;
						ns     = ST_VAL;
					end else if (c == xtl_pkg::CH_SQ) begin
						nquote = 1'b1;
						ns     = ST_VAL;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_ERR, 8'd0, 1'b0, 1'b1); n++;
						ns = ST_TAG;
					end
				end
				ST_VAL: begin
					if (c == (quote_q ? xtl_pkg::CH_SQ : xtl_pkg::CH_DQ)) begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_AVAL, 8'd0, 1'b0, 1'b1); n++;
						ns = ST_TAG;
					end else if (c == xtl_pkg::CH_AMP) begin
						nlen = '0;
						ns   = ST_VAL_ENT;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_AVAL, c, 1'b1, 1'b0); n++;
					end
				end
				default: begin
					ns = ST_OUT;
					if (c == xtl_pkg::CH_LT) begin
						if (open_q) begin
							res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_TEXT, 8'd0, 1'b0, 1'b1); n++;
							nopen = 1'b0;
						end
						ns = ST_LT;
					end else if (c == xtl_pkg::CH_AMP) begin
						nopen = 1'b1;
						nlen  = '0;
						ns    = ST_TEXT_ENT;
					end else begin
						res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_TEXT, c, 1'b1, 1'b0); n++;
						nopen  = 1'b1;
					end
				end
			endcase
			// handle the byte as a tag-level byte
			if (do_tag) begin
				ns = ST_TAG;
				if (xtl_pkg::is_space(c)) ns = ST_TAG;
				else if (c == xtl_pkg::CH_GT) begin
					res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_TAGEND, 8'd0, 1'b0, 1'b1); n++;
					ns = ST_OUT;
				end else if (c == xtl_pkg::CH_QM) ns = ST_TAG_QM;
				else if (c == xtl_pkg::CH_SLASH) ns = ST_TAG_SLASH;
				else if (c == xtl_pkg::CH_EQ) ns = ST_EQ;
				else if (xtl_pkg::is_name(c)) begin
					res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_ANAME, c, 1'b1, 1'b0); n++;
					ns = ST_ANAME;
				end else begin
					res[n[1:0]] = xtl_pkg::mk(xtl_pkg::K_ERR, 8'd0, 1'b0, 1'b1); n++;
				end
			end
		end
	end

	assign push          = acc && (n != 3'd0);
	assign push_data.res = res;
	assign push_data.cnt = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_OUT;
			held_q  <= 2'd0;
			len_q   <= '0;
			kw_q    <= 3'd0;
			quote_q <= 1'b0;
			open_q  <= 1'b0;
		end else if (acc) begin
			state_q <= ns;
			held_q  <= nheld;
			len_q   <= nlen;
			kw_q    <= nkw;
			quote_q <= nquote;
			open_q  <= nopen;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && ent_we)
			ent_q[len_q[IW-1:0]] <= c;
	end

endmodule

>>> design/xtl_queue.sv
module xtl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  xtl_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output xtl_pkg::bundle_t pop_data,
	output logic             empty
);

	localparam int unsigned AW = $clog2(xtl_pkg::QDEPTH);

	xtl_pkg::bundle_t mem_q [xtl_pkg::QDEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;

	assign full     = (cnt_q == (AW+1)'(xtl_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + AW'(1);
			if (pop && !empty) rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end

endmodule

>>> design/xtl_back.sv
module xtl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  xtl_pkg::bundle_t head,
	input  logic             empty,
	output logic             pop,
	xtl_out_if.source        tokens
);

	logic [1:0]    idx_q;
	logic          at_last;
	xtl_pkg::res_t cur;

	assign cur     = head.res[idx_q];
	assign at_last = ({1'b0, idx_q} == head.cnt - 3'd1);

	assign tokens.valid       = !empty;
	assign tokens.token_kind  = cur.kind;
	assign tokens.out_char    = cur.ch;
	assign tokens.char_valid  = cur.valid;
	assign tokens.token_last  = cur.last;
	assign tokens.result_last = at_last;

	assign pop = tokens.valid && tokens.ready && at_last;

	// advance through the bundle, drop it after its last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (tokens.valid && tokens.ready) begin
			idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

>>> design/xml_token_lexer_unit.sv
// XML token lexer. Feed one byte of the stream per transaction on items, or
// a transaction with end_of_stream set to close the stream; the lexer then
// returns to its reset state. Each transaction on tokens carries one token
// character or token-closing mark, tagged with its kind; result_last marks
// the final result caused by one input byte. The front stage classifies a
// byte combinationally and packs its zero to four results into one bundle;
// a four-entry bundle queue decouples it from the back stage, which sends one
// result per cycle while ready is high. Input rate is one byte per cycle while
// the queue has room; sustained throughput is bounded by the output port at
// one result per cycle, so k results cost k transfers. Bytes that cause no
// result (spaces in a tag, entity letters, held dashes) never occupy the queue.
module xml_token_lexer_unit #(
	parameter int unsigned ENTITY_NAME_MAX = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	xtl_in_if.sink    items,
	xtl_out_if.source tokens
);

	// front to queue
	logic             push;
	xtl_pkg::bundle_t push_data;
	logic             full;

	// queue to back
	logic             pop;
	xtl_pkg::bundle_t head;
	logic             empty;

	// classify each byte and update the lexer state
	xtl_front #(
		.ENTITY_NAME_MAX(ENTITY_NAME_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.full     (full),
		.push     (push),
		.push_data(push_data)
	);

	// hold result bundles so either side can stall
	xtl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (head),
		.empty    (empty)
	);

	// serialize bundles into one result per transaction
	xtl_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.tokens(tokens)
	);

endmodule

>>> bench/tb_xml_token_lexer_unit.sv
module tb_xml_token_lexer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;

	// lexer positions, same encoding as the block's sub-state
	typedef enum int {
		S_OUT, S_TEXT_ENT, S_LT, S_BANG, S_CMT_DASH, S_CMT, S_CD_KEY, S_CD,
		S_PI, S_DIR, S_ETAG, S_STAG, S_TAG, S_TAG_SLASH, S_TAG_QM, S_EQ,
		S_VAL, S_VAL_ENT, S_ANAME
	} lex_pos_t;

	typedef struct {
		logic [7:0] b;
		logic       eos;
	} stream_byte_t;

	typedef struct {
		xtl_pkg::kind_t kind;
		logic [7:0] ch;
		logic       cv;
		logic       tl;
		logic       rl;
	} token_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	xtl_in_if  items ();
	xtl_out_if tokens ();

	xml_token_lexer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.tokens (tokens)
	);

	always #5 clk = ~clk;

	stream_byte_t byte_queue[$];
	token_res_t   step_toks[$];
	token_res_t   token_expect[$];

	int unsigned n_errors = 0;
	int unsigned n_in = 0;
	int unsigned cycles = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned hold_off = 0;
	bit          hold_done = 1'b0;

	// ---------------------------------------------------------------
	// Lexer predictor: own copy of the state
	// ---------------------------------------------------------------
	lex_pos_t   lx_pos = S_OUT;
	int unsigned lx_held = 0;
	logic [7:0] lx_ent[4];
	int unsigned lx_elen = 0;
	int unsigned lx_kw = 0;
	bit         lx_squote = 0;
	bit         lx_open = 0;

	function automatic bit blank(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
	endfunction

	function automatic bit namechar(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" ||
			c == ":" || c == "-" || c == "." || (c >= "0" && c <= "9");
	endfunction

	function automatic void put(xtl_pkg::kind_t k, logic [7:0] ch, bit v, bit l);
		token_res_t t;
		t.kind = k; t.ch = ch; t.cv = v; t.tl = l; t.rl = 1'b0;
		step_toks.push_back(t);
	endfunction

	function automatic void ent_add(logic [7:0] c);
		if (lx_elen < 4) begin
			lx_ent[lx_elen] = c;
			lx_elen++;
		end else begin
			lx_elen = 5;
		end
	endfunction

	// decoded entity code, -1 when the name is not one of the five
	function automatic int ent_code();
		string nm;
		nm = "";
		if (lx_elen > 4)
			return -1;
		for (int i = 0; i < lx_elen; i++)
			nm = {nm, string'(lx_ent[i])};
		case (nm)
			"amp":   return "&";
			"lt":    return "<";
			"gt":    return ">";
			"apos":  return "'";
			"quot":  return "\"";
			default: return -1;
		endcase
	endfunction

	function automatic xtl_pkg::kind_t kind_of_name(lex_pos_t p);
		case (p)
			S_PI:    return xtl_pkg::K_PI;
			S_DIR:   return xtl_pkg::K_DIR;
			S_ETAG:  return xtl_pkg::K_ETAG;
			S_STAG:  return xtl_pkg::K_STAG;
			default: return xtl_pkg::K_ANAME;
		endcase
	endfunction

	function automatic void tag_byte(logic [7:0] c);
		if (blank(c))
			return;
		if (c == ">") begin
			put(xtl_pkg::K_TAGEND, 0, 0, 1);
			lx_pos = S_OUT;
		end else if (c == "?") lx_pos = S_TAG_QM;
		else if (c == "/") lx_pos = S_TAG_SLASH;
		else if (c == "=") lx_pos = S_EQ;
		else if (namechar(c)) begin
			put(xtl_pkg::K_ANAME, c, 1, 0);
			lx_pos = S_ANAME;
		end else begin
			put(xtl_pkg::K_ERR, 0, 0, 1);
		end
	endfunction

	// returns 1 when the byte closed the name and goes on to the tag
	function automatic bit name_byte(logic [7:0] c);
		if (namechar(c)) begin
			put(kind_of_name(lx_pos), c, 1, 0);
			return 0;
		end
		put(kind_of_name(lx_pos), 0, 0, 1);
		lx_pos = S_TAG;
		return 1;
	endfunction

	function automatic void flush_marks(xtl_pkg::kind_t k, logic [7:0] m);
		for (int i = 0; i < lx_held && i < 2; i++)
			put(k, m, 1, 0);
		lx_held = 0;
	endfunction

	function automatic void body_byte(xtl_pkg::kind_t k, logic [7:0] m, logic [7:0] c);
		if (c == m) begin
			if (lx_held < 2) lx_held++;
			else put(k, m, 1, 0);
		end else if (c == ">" && lx_held == 2) begin
			lx_held = 0;
			put(k, 0, 0, 1);
			lx_pos = S_OUT;
		end else begin
			flush_marks(k, m);
			put(k, c, 1, 0);
		end
	endfunction

	function automatic bit lex_byte(logic [7:0] c);
		int code;
		case (lx_pos)
			S_TEXT_ENT, S_VAL_ENT: begin
				if (c != ";") begin
					ent_add(c);
					return 0;
				end
				code = ent_code();
				if (lx_pos == S_TEXT_ENT) begin
					if (code >= 0) put(xtl_pkg::K_TEXT, code[7:0], 1, 0);
					else begin
						put(xtl_pkg::K_TEXT, 0, 0, 1);
						lx_open = 0;
					end
					lx_pos = S_OUT;
				end else if (code >= 0) begin
					put(xtl_pkg::K_AVAL, code[7:0], 1, 0);
					lx_pos = S_VAL;
				end else begin
					put(xtl_pkg::K_AVAL, 0, 0, 1);
					lx_pos = S_TAG;
				end
			end
			S_LT: begin
				if (c == "?") lx_pos = S_PI;
				else if (c == "!") lx_pos = S_BANG;
				else if (c == "/") lx_pos = S_ETAG;
				else begin
					lx_pos = S_STAG;
					return name_byte(c);
				end
			end
			S_BANG: begin
				if (c == "-") lx_pos = S_CMT_DASH;
				else if (c == "[") begin
					lx_kw = 0;
					lx_pos = S_CD_KEY;
				end else begin
					lx_pos = S_DIR;
					return name_byte(c);
				end
			end
			S_CMT_DASH: begin
				if (c == "-") begin
					lx_held = 0;
					lx_pos = S_CMT;
				end else begin
					put(xtl_pkg::K_ERR, 0, 0, 1);
					lx_pos = S_OUT;
				end
			end
			S_CMT: body_byte(xtl_pkg::K_CMT, "-", c);
			S_CD:  body_byte(xtl_pkg::K_CD, "]", c);
			S_CD_KEY: begin
				if (namechar(c)) begin
					if (lx_kw < 5 && c == xtl_pkg::cdata_char(3'(lx_kw))) lx_kw++;
					else lx_kw = 7;
				end else if (lx_kw == 5 && c == "[") begin
					lx_held = 0;
					lx_pos = S_CD;
				end else begin
					put(xtl_pkg::K_ERR, 0, 0, 1);
					lx_pos = S_OUT;
				end
			end
			S_PI, S_DIR, S_ETAG, S_STAG, S_ANAME: return name_byte(c);
			S_TAG: tag_byte(c);
			S_TAG_SLASH, S_TAG_QM: begin
				if (c == ">") begin
					put(xtl_pkg::K_TAGEND, lx_pos == S_TAG_SLASH ? "/" : "?", 1, 1);
					lx_pos = S_OUT;
				end else begin
					put(xtl_pkg::K_ERR, 0, 0, 1);
					lx_pos = S_TAG;
				end
			end
			S_EQ: begin
				if (blank(c)) return 0;
				if (c == "\"") begin
					lx_squote = 0;
					lx_pos = S_VAL;
				end else if (c == "'") begin
					lx_squote = 1;
					lx_pos = S_VAL;
				end else begin
					put(xtl_pkg::K_ERR, 0, 0, 1);
					lx_pos = S_TAG;
				end
			end
			S_VAL: begin
				if (c == (lx_squote ? "'" : "\"")) begin
					put(xtl_pkg::K_AVAL, 0, 0, 1);
					lx_pos = S_TAG;
				end else if (c == "&") begin
					lx_elen = 0;
					lx_pos = S_VAL_ENT;
				end else begin
					put(xtl_pkg::K_AVAL, c, 1, 0);
				end
			end
			default: begin
				lx_pos = S_OUT;
				if (c == "<") begin
					if (lx_open) begin
						put(xtl_pkg::K_TEXT, 0, 0, 1);
						lx_open = 0;
					end
					lx_pos = S_LT;
				end else if (c == "&") begin
					lx_open = 1;
					lx_elen = 0;
					lx_pos = S_TEXT_ENT;
				end else begin
					put(xtl_pkg::K_TEXT, c, 1, 0);
					lx_open = 1;
				end
			end
		endcase
		return 0;
	endfunction

	function automatic void lex_close();
		int code;
		case (lx_pos)
			S_TEXT_ENT: begin
				code = ent_code();
				if (code >= 0) put(xtl_pkg::K_TEXT, code[7:0], 1, 0);
				put(xtl_pkg::K_TEXT, 0, 0, 1);
			end
			S_LT, S_BANG, S_CMT_DASH, S_CD_KEY, S_TAG, S_TAG_SLASH, S_TAG_QM, S_EQ:
				put(xtl_pkg::K_ERR, 0, 0, 1);
			S_CMT: begin
				flush_marks(xtl_pkg::K_CMT, "-");
				put(xtl_pkg::K_CMT, 0, 0, 1);
			end
			S_CD: begin
				flush_marks(xtl_pkg::K_CD, "]");
				put(xtl_pkg::K_CD, 0, 0, 1);
			end
			S_PI, S_DIR, S_ETAG, S_STAG, S_ANAME: begin
				put(kind_of_name(lx_pos), 0, 0, 1);
				put(xtl_pkg::K_ERR, 0, 0, 1);
			end
			S_VAL: begin
				put(xtl_pkg::K_AVAL, 0, 0, 1);
				put(xtl_pkg::K_ERR, 0, 0, 1);
			end
			S_VAL_ENT: begin
				code = ent_code();
				if (code >= 0) put(xtl_pkg::K_AVAL, code[7:0], 1, 0);
				put(xtl_pkg::K_AVAL, 0, 0, 1);
				put(xtl_pkg::K_ERR, 0, 0, 1);
			end
			default: if (lx_open) put(xtl_pkg::K_TEXT, 0, 0, 1);
		endcase
		put(xtl_pkg::K_EOF, 0, 0, 1);
		lx_pos = S_OUT;
		lx_held = 0;
		lx_elen = 0;
		lx_kw = 0;
		lx_squote = 0;
		lx_open = 0;
	endfunction

	// run one accepted byte through the predictor, queue its tokens
	function automatic void predict_tokens(stream_byte_t sb);
		step_toks.delete();
		if (sb.eos) lex_close();
		else if (lex_byte(sb.b)) tag_byte(sb.b);
		if (step_toks.size() > 0)
			step_toks[step_toks.size()-1].rl = 1'b1;
		foreach (step_toks[i])
			token_expect.push_back(step_toks[i]);
	endfunction

	// ---------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------
	task automatic push_byte(logic [7:0] b, logic eos = 1'b0);
		stream_byte_t sb;
		sb.b = b;
		sb.eos = eos;
		byte_queue.push_back(sb);
	endtask

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_eos();
		push_byte(8'($urandom), 1'b1);
	endtask

	function automatic string rand_name(int unsigned maxlen);
		string s;
		string pool;
		s = "";
		pool = "abcxyzABCZ_:-.09";
		repeat ($urandom_range(1, maxlen))
			s = {s, string'(pool[$urandom_range(0, pool.len()-1)])};
		return s;
	endfunction

	function automatic string rand_entity();
		case ($urandom_range(0, 7))
			0: return "&amp;";
			1: return "&lt;";
			2: return "&gt;";
			3: return "&apos;";
			4: return "&quot;";
			5: return "&ampx;";
			6: return "&quotes;";
			default: return {"&", rand_name(6), ";"};
		endcase
	endfunction

	function automatic string rand_text(string bad);
		string s;
		string pool;
		s = "";
		pool = "ab -]Z9\n>.";
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 3) == 0 && bad == "") s = {s, rand_entity()};
			else s = {s, string'(pool[$urandom_range(0, pool.len()-1)])};
		end
		return s;
	endfunction

	// well-formed fragment with random content, sometimes broken markup, raw random bytes or an end of stream
	task automatic push_fragment();
		string s;
		string q;
		case ($urandom_range(0, 11))
			0, 1: push_str(rand_text(""));
			2: push_str({"<!--", rand_text("x"), ($urandom_range(0, 1) ? "--->" : "-->")});
			3: push_str({"<![CDATA[", rand_text("x"), ($urandom_range(0, 1) ? "]]]>" : "]]>")});
			4: push_str({"<?", rand_name(4), " ", rand_name(3), "?>"});
			5: push_str({"<!", rand_name(5), " ", rand_name(3), ">"});
			6: push_str({"</", rand_name(4), ">"});
			7, 8: begin
				s = {"<", rand_name(4)};
				repeat ($urandom_range(0, 3)) begin
					q = $urandom_range(0, 1) ? "'" : "\"";
					s = {s, " ", rand_name(4), ($urandom_range(0, 1) ? " = " : "="), q};
					repeat ($urandom_range(0, 4))
						s = {s, ($urandom_range(0, 2) == 0) ? rand_entity() : rand_name(2)};
					s = {s, q};
				end
				s = {s, ($urandom_range(0, 2) == 0) ? "/>" : ">"};
				push_str(s);
			end
			9: begin
				// broken markup
				case ($urandom_range(0, 5))
					0: push_str("<!-x");
					1: push_str({"<![CDAT", rand_name(2), "["});
					2: push_str("<a /x>");
					3: push_str("<a x=y>");
					4: push_str("<a ?b ! >");
					default: push_str("<[ &toolongname;>");
				endcase
			end
			10: repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
			default: push_eos();
		endcase
	endtask

	// ---------------------------------------------------------------
	// Driver: offer bytes from the queue
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items.valid <= 1'b0;
			items.in_byte <= 8'h00;
			items.end_of_stream <= 1'b0;
		end else if (!items.valid || items.ready) begin
			if (byte_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				items.valid <= 1'b1;
				items.in_byte <= byte_queue[0].b;
				items.end_of_stream <= byte_queue[0].eos;
				void'(byte_queue.pop_front());
			end else begin
				items.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stalls plus one long hold-off
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tokens.ready <= 1'b0;
		end else begin
			if (!hold_done && n_in >= 200) begin
				hold_done <= 1'b1;
				hold_off <= 300;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
			end
			tokens.ready <= (hold_off == 0) && hold_done | (n_in < 200) &&
				($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// ---------------------------------------------------------------
	// Monitor: predict on accepted input, check accepted results
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (items.valid && items.ready) begin
				predict_tokens('{b: items.in_byte, eos: items.end_of_stream});
				n_in <= n_in + 1;
			end
			if (tokens.valid && tokens.ready) begin
				if (token_expect.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected token result kind=%0d char=%h", $realtime,
						tokens.token_kind, tokens.out_char);
				end else begin
					token_res_t e;
					e = token_expect.pop_front();
					if (tokens.token_kind !== e.kind || tokens.out_char !== e.ch ||
						tokens.char_valid !== e.cv || tokens.token_last !== e.tl ||
						tokens.result_last !== e.rl) begin
						n_errors++;
						$display({"%0t: expected kind=%0d ch=%h cv=%b tl=%b rl=%b, ",
							"got kind=%0d ch=%h cv=%b tl=%b rl=%b"},
							$realtime, e.kind, e.ch, e.cv, e.tl, e.rl,
							tokens.token_kind, tokens.out_char, tokens.char_valid,
							tokens.token_last, tokens.result_last);
					end
				end
			end
		end
	end

	// idling phases move with the number of accepted bytes
	always @(posedge clk) begin
		case ((n_in / 120) % 4)
			0: begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
			1: begin src_idle_pct <= 84; snk_stall_pct <= 0;  end
			2: begin src_idle_pct <= 0;  snk_stall_pct <= 84; end
			default: begin src_idle_pct <= 26; snk_stall_pct <= 26; end
		endcase
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		// directed: entities, bodies with held marks, names, errors, byte extremes
		push_str("a&amp;&lt;&gt;&apos;&quot;&ampx;");
		push_str("<!-- a-b---><![CDATA[x]]]>");
		push_str("<?p?><!D></e><a x=\"&lt;&zz;\" y='v'/>");
		push_str("<!-x<![CDATX[<a /x =y \x01>");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_str("<a b='&quot");
		push_eos();
		push_str("<!--ab--");
		push_eos();
		push_eos();
		while (byte_queue.size() < 470)
			push_fragment();
		push_eos();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (byte_queue.size() > 0 || items.valid || token_expect.size() > 0);
		repeat (40) @(negedge clk);

		if (n_errors == 0 && token_expect.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
